/* hw/rtl/tgh_pkg.sv */
// shared types and constants of the twin gaussian log scale rate pipeline
`default_nettype none

package tgh_pkg;

    // fraction bits of the user fixed point formats
    localparam int FRAC_BITS = 16;

    // ln(scale factor) in Q32, signed
    localparam int X_W = 41;
    // amplitude times exp, Q(FRAC_BITS+32), signed
    localparam int BUMP_W = 51;

    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam logic [30:0] LOG2E_FRAC_Q32 = 31'd1901360723;

    // quotient bits of the normalized distance, root bits of the rate
    localparam int DIV_BITS  = 20;
    localparam int SQRT_BITS = 32;

    // fixed latencies around the refinement stages
    localparam int LOG_FIXED_LAT  = 3;
    localparam int BUMP_FIXED_LAT = DIV_BITS + 7;
    localparam int RATE_LAT       = SQRT_BITS + 5;

    typedef enum logic [2:0] {
        CFG_AMP1,
        CFG_AMP2,
        CFG_CEN1,
        CFG_CEN2,
        CFG_WID1,
        CFG_WID2,
        CFG_COEF
    } cfg_idx_t;

    typedef struct packed {
        logic signed [18:0] gravity_ratio;
        logic [31:0]        expansion_rate;
        logic               bad_input;
        logic               saturated;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/tgh_ctrl.sv */
// valid bits of the pipeline and the two entry result buffer
`default_nettype none

module tgh_ctrl
    import tgh_pkg::*;
#(
    parameter int DEPTH = 107
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         en,
    input  wire result_t pipe_res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic [DEPTH-1:0] valid_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    result_t          buf0_reg;
    result_t          buf1_reg;
    logic             push;
    logic             pop;

    // pipeline moves while the buffer has room for one more result
    assign en        = (count_reg != 2'd2);
    assign in_ready  = en;
    assign push      = en && valid_reg[DEPTH-1];
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = buf0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            buf0_reg <= pipe_res;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                buf0_reg <= pipe_res;
            end
            else
            begin
                buf1_reg <= pipe_res;
            end
        end
        else if (pop)
        begin
            buf0_reg <= buf1_reg;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tgh_log.sv */
// natural log of the scale factor by repeated squaring, one bit per stage
`default_nettype none

module tgh_log
    import tgh_pkg::*;
#(
    parameter int STAGES = 20
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [31:0]           scale_factor,
    output logic signed [X_W-1:0]      x_q32
);

    logic [4:0]  lead;
    logic [31:0] norm;

    logic [31:0] m_reg    [0:STAGES-1];
    logic [31:0] frac_reg [0:STAGES];
    logic [4:0]  lead_reg [0:STAGES];

    logic [63:0]        prod_reg;
    logic signed [39:0] ip_reg;
    logic signed [6:0]  pexp;

    // leading one and normalization to [1, 2) in Q31
    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (scale_factor[i])
            begin
                lead = 5'(i);
            end
        end
        norm = scale_factor << (5'd31 - lead);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= norm;
            frac_reg[0] <= '0;
            lead_reg[0] <= lead;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= STAGES; k++)
        begin : g_sq
            logic [63:0] sq;
            logic [32:0] sh;
            logic [31:0] frac_set;

            assign sq = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
            assign sh = sq[63:31];

            always_comb
            begin
                frac_set         = frac_reg[k-1];
                frac_set[32 - k] = 1'b1;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    frac_reg[k] <= sh[32] ? frac_set : frac_reg[k-1];
                    lead_reg[k] <= lead_reg[k-1];
                end
            end

            if (k < STAGES)
            begin : g_m
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        m_reg[k] <= sh[32] ? sh[32:1] : sh[31:0];
                    end
                end
            end
        end
    endgenerate

    assign pexp = $signed({2'b00, lead_reg[STAGES]}) - 7'sd30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 64'(frac_reg[STAGES]) * 64'(LN2_Q32);
            ip_reg   <= pexp * $signed({8'b0, LN2_Q32});
            x_q32    <= X_W'(ip_reg) + X_W'($signed({1'b0, prod_reg[63:32]}));
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tgh_bump.sv */
// one gaussian bump: distance, divide by width, exp(-u^2/2), times amplitude
`default_nettype none

module tgh_bump
    import tgh_pkg::*;
#(
    parameter int STAGES = 20
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [X_W-1:0]    x_q32,
    input  wire logic signed [17:0]       amplitude,
    input  wire logic signed [20:0]       centre,
    input  wire logic [17:0]              width,
    output logic signed [BUMP_W-1:0]      bump_val,
    output logic                          clipped
);

    localparam int BL      = BUMP_FIXED_LAT + STAGES;
    localparam int S_T     = DIV_BITS + 2;
    localparam int S_V     = S_T + 2;
    localparam int S_SHIFT = S_V + STAGES + 1;
    localparam logic [38:0] DIST_MAX = '1;

    function automatic logic [31:0] isqrt64(input logic [63:0] n);
        logic [31:0] res;
        logic [31:0] cand;
        res = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = res | (32'd1 << b);
            if (64'(cand) * 64'(cand) <= n)
            begin
                res = cand;
            end
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q32 as the chain of floor square roots from one half
    function automatic logic [31:0] pow_factor(input int kk);
        logic [31:0] r;
        r = 32'h8000_0000;
        for (int i = 1; i <= 32; i++)
        begin
            if (i <= kk)
            begin
                r = isqrt64({r, 32'b0});
            end
        end
        return r;
    endfunction

    logic zero_reg [0:BL-2];
    logic zero_add [1:BL-2];
    logic clip_reg [0:BL-1];

    logic signed [41:0] cen_q32;
    logic signed [41:0] delta;
    logic [41:0]        adist;
    logic               far;
    logic [38:0]        ud_reg;

    logic [38:0] rem_reg [1:DIV_BITS];
    logic [DIV_BITS-1:0] q_reg [1:DIV_BITS+1];

    logic [38:0] t_reg;
    logic [38:0] t2_reg;
    logic [37:0] mhi_reg;
    logic [62:0] mlo_reg;
    logic [39:0] v;

    logic [31:0] f_reg [S_V:S_V+STAGES-1];
    logic [5:0]  n_reg [S_V:S_V+STAGES];
    logic [32:0] r_reg [S_V:S_V+STAGES];
    logic [32:0] sh_reg;
    logic signed [BUMP_W-1:0] amp_prod;

    // distance to the centre, clipped
    assign cen_q32 = 42'(centre) <<< (32 - FRAC_BITS);
    assign delta   = 42'(x_q32) - cen_q32;
    assign adist   = delta[41] ? 42'(-delta) : 42'(delta);
    assign far     = adist > 42'(DIST_MAX);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg      <= far ? DIST_MAX : adist[38:0];
            clip_reg[0] <= far && (width != '0);
            zero_reg[0] <= (width == '0);
        end
    end

    genvar s;
    generate
        for (s = 1; s <= BL - 2; s++)
        begin : g_zero
            if (s == 1)
            begin : g_ovf
                assign zero_add[s] = ({1'b0, ud_reg} >= {2'b00, width, 20'b0});
            end
            else if (s == S_V)
            begin : g_big
                assign zero_add[s] = (v[39:32] >= 8'd33);
            end
            else
            begin : g_none
                assign zero_add[s] = 1'b0;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[s] <= zero_reg[s-1] | zero_add[s];
                end
            end
        end

        for (s = 1; s <= BL - 1; s++)
        begin : g_clip
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    clip_reg[s] <= clip_reg[s-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[1] <= ud_reg;
            q_reg[1]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    genvar j;
    generate
        for (j = 0; j < DIV_BITS; j++)
        begin : g_div
            localparam int QB = DIV_BITS - 1 - j;
            logic [38:0] dv;
            logic        take;
            logic [DIV_BITS-1:0] q_set;

            assign dv   = 39'(width) << QB;
            assign take = rem_reg[j+1] >= dv;

            always_comb
            begin
                q_set     = q_reg[j+1];
                q_set[QB] = 1'b1;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[j+2] <= take ? q_set : q_reg[j+1];
                end
            end

            if (j < DIV_BITS - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j+2] <= take ? rem_reg[j+1] - dv : rem_reg[j+1];
                    end
                end
            end
        end
    endgenerate

    // t = u^2/2, then v = t * log2(e)
    assign v = 40'(t2_reg) + 40'(mhi_reg) + 40'(mlo_reg[62:32]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= 39'((40'(q_reg[DIV_BITS+1]) * 40'(q_reg[DIV_BITS+1])) >> 1);
            t2_reg  <= t_reg;
            mhi_reg <= 38'(t_reg[38:32]) * 38'(LOG2E_FRAC_Q32);
            mlo_reg <= 63'(t_reg[31:0]) * 63'(LOG2E_FRAC_Q32);
            f_reg[S_V] <= v[31:0];
            n_reg[S_V] <= v[37:32];
            r_reg[S_V] <= 33'h1_0000_0000;
        end
    end

    // 2^-frac, one fraction bit per stage
    genvar e;
    generate
        for (e = 1; e <= STAGES; e++)
        begin : g_exp
            localparam logic [31:0] FACTOR = pow_factor(e);
            logic [64:0] prod;

            assign prod = 65'(r_reg[S_V+e-1]) * 65'(FACTOR);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[S_V+e] <= f_reg[S_V+e-1][32-e] ? prod[64:32] : r_reg[S_V+e-1];
                    n_reg[S_V+e] <= n_reg[S_V+e-1];
                end
            end

            if (e < STAGES)
            begin : g_f
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        f_reg[S_V+e] <= f_reg[S_V+e-1];
                    end
                end
            end
        end
    endgenerate

    assign amp_prod = amplitude * $signed({1'b0, sh_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg   <= r_reg[S_V+STAGES] >> n_reg[S_V+STAGES];
            bump_val <= zero_reg[S_SHIFT] ? '0 : amp_prod;
        end
    end

    assign clipped = clip_reg[BL-1];

endmodule

`default_nettype wire

/* hw/rtl/tgh_rate.sv */
// gravity ratio rounding and clip, squared rate, overflow check, square root
`default_nettype none

module tgh_rate
    import tgh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [BUMP_W-1:0] bump1,
    input  wire logic signed [BUMP_W-1:0] bump2,
    input  wire logic                     clip1,
    input  wire logic                     clip2,
    input  wire logic [31:0]              density,
    input  wire logic                     bad_in,
    input  wire logic [31:0]              coefficient,
    output result_t                       res
);

    localparam int SUM_W = BUMP_W + 2;
    localparam int S_SQ  = 3;
    localparam int S_END = S_SQ + SQRT_BITS;
    localparam logic signed [SUM_W-1:0] ONE   = SUM_W'(1) <<< (FRAC_BITS + 32);
    localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1) <<< 31;
    localparam logic signed [20:0] RATIO_MIN  = -21'sd262144;
    localparam logic signed [20:0] RATIO_MAX  = 21'sd262143;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] rnd;
    logic signed [20:0]      g_full;
    logic signed [18:0]      g_clip;
    logic                    g_sat;
    logic [63:0]             p1_reg [0:1];

    logic signed [18:0] g_reg    [1:S_END];
    logic               sat_reg  [0:S_END];
    logic               bad_reg  [0:S_END];
    logic               over_reg [S_SQ:S_END];

    logic        gpos_reg;
    logic [49:0] hi_reg;
    logic [49:0] lo_reg;
    logic [64:0] s_wide;

    logic [63:0] num_reg  [S_SQ:S_END-1];
    logic [63:0] root_reg [S_SQ:S_END];

    assign rnd    = sum_reg + HALF;
    assign g_full = rnd[SUM_W-1:32];

    always_comb
    begin
        g_clip = g_full[18:0];
        g_sat  = 1'b0;
        if (g_full < RATIO_MIN)
        begin
            g_clip = RATIO_MIN[18:0];
            g_sat  = 1'b1;
        end
        else if (g_full > RATIO_MAX)
        begin
            g_clip = RATIO_MAX[18:0];
            g_sat  = 1'b1;
        end
    end

    assign s_wide = 65'({hi_reg[47:0], 16'b0}) + 65'(lo_reg[49:16]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg    <= ONE + SUM_W'(bump1) + SUM_W'(bump2);
            p1_reg[0]  <= 64'(coefficient) * 64'(density);
            sat_reg[0] <= clip1 | clip2;
            bad_reg[0] <= bad_in;

            g_reg[1]   <= g_clip;
            p1_reg[1]  <= p1_reg[0];

            gpos_reg   <= !g_reg[1][18] && (g_reg[1] != '0);
            hi_reg     <= 50'(p1_reg[1][63:32]) * 50'(g_reg[1][17:0]);
            lo_reg     <= 50'(p1_reg[1][31:0]) * 50'(g_reg[1][17:0]);

            over_reg[S_SQ] <= gpos_reg && ((hi_reg[49:48] != 2'b00) || s_wide[64]);
            num_reg[S_SQ]  <= gpos_reg ? s_wide[63:0] : '0;
            root_reg[S_SQ] <= '0;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= S_END; s++)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sat_reg[s] <= (s == 1) ? (sat_reg[s-1] | g_sat) : sat_reg[s-1];
                    bad_reg[s] <= bad_reg[s-1];
                end
            end
        end

        for (s = 2; s <= S_END; s++)
        begin : g_gcarry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    g_reg[s] <= g_reg[s-1];
                end
            end
        end

        for (s = S_SQ + 1; s <= S_END; s++)
        begin : g_ocarry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    over_reg[s] <= over_reg[s-1];
                end
            end
        end
    endgenerate

    // digit by digit square root, one root bit per stage
    genvar j;
    generate
        for (j = 0; j < SQRT_BITS; j++)
        begin : g_sqrt
            logic [63:0] rbit;
            logic [64:0] trial;
            logic        take;

            assign rbit  = 64'(1) << (62 - 2 * j);
            assign trial = 65'(root_reg[S_SQ+j]) + 65'(rbit);
            assign take  = 65'(num_reg[S_SQ+j]) >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[S_SQ+j+1] <= take ? (root_reg[S_SQ+j] >> 1) + rbit
                                               : (root_reg[S_SQ+j] >> 1);
                end
            end

            if (j < SQRT_BITS - 1)
            begin : g_num
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        num_reg[S_SQ+j+1] <= take ? num_reg[S_SQ+j] - trial[63:0]
                                                  : num_reg[S_SQ+j];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res.bad_input <= bad_reg[S_END];
            if (bad_reg[S_END])
            begin
                res.gravity_ratio  <= '0;
                res.expansion_rate <= '0;
                res.saturated      <= 1'b0;
            end
            else
            begin
                res.gravity_ratio  <= g_reg[S_END];
                res.expansion_rate <= over_reg[S_END] ? '1 : root_reg[S_END][31:0];
                res.saturated      <= sat_reg[S_END] | over_reg[S_END];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/twin_gaussian_log_scale_hubble.sv */
// top level: twin gaussian gravity ratio and expansion rate pipeline
`default_nettype none

// Takes one beat per cycle (scale factor Q2.30, density Q16.16) and returns,
// in order, the gravity ratio g = 1 + two gaussian bumps in ln(scale factor)
// (signed Q2.16) and the expansion rate sqrt(coef * g * density) (Q16.16).
// Throughput is one beat per clock. The log takes one squaring stage per
// result bit, the exponential one multiply stage per fraction bit, the
// width divide one stage per quotient bit and the square root one stage
// per root bit. Results land in a two entry buffer; the pipeline holds
// only when both entries are full, so a waiting result does not block
// new beats. A zero scale factor returns bad_input with all other fields
// zero. saturated flags a clipped log distance, a clipped ratio or an
// overflowing rate (then all ones). Configuration is written through
// cfg_write/cfg_index/cfg_data and must only change while the pipeline is
// empty; indexes beyond the seven registers are ignored.

module twin_gaussian_log_scale_hubble
    import tgh_pkg::*;
#(
    parameter int CORDIC_STAGES = 20
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        scale_factor,
    input  wire logic [31:0]        density,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [18:0]      gravity_ratio,
    output logic [31:0]             expansion_rate,
    output logic                    bad_input,
    output logic                    saturated,

    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int LOG_LAT  = LOG_FIXED_LAT + CORDIC_STAGES;
    localparam int BUMP_LAT = BUMP_FIXED_LAT + CORDIC_STAGES;
    localparam int PRE_LAT  = LOG_LAT + BUMP_LAT;
    localparam int DEPTH    = PRE_LAT + RATE_LAT;

    // register reset values
    localparam logic signed [17:0] AMP1_RST = 18'sd6554;
    localparam logic signed [17:0] AMP2_RST = 18'sd3277;
    localparam logic signed [20:0] CEN1_RST = -21'sd524288;
    localparam logic signed [20:0] CEN2_RST = -21'sd32768;
    localparam logic [17:0]        WID_RST  = 18'd32768;
    localparam logic [31:0]        COEF_RST = 32'd549033;

    logic signed [17:0] amp1_reg;
    logic signed [17:0] amp2_reg;
    logic signed [20:0] cen1_reg;
    logic signed [20:0] cen2_reg;
    logic [17:0]        wid1_reg;
    logic [17:0]        wid2_reg;
    logic [31:0]        coef_reg;

    // global advance, low only while the result buffer is full
    logic    en;
    result_t pipe_res;
    result_t out_res;

    logic signed [X_W-1:0]    x_q32;
    logic signed [BUMP_W-1:0] bump1;
    logic signed [BUMP_W-1:0] bump2;
    logic                     clip1;
    logic                     clip2;

    // density and zero-input flag ride alongside log and bump stages
    logic [31:0] dens_line_reg [0:PRE_LAT-1];
    logic        bad_line_reg  [0:PRE_LAT-1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp1_reg <= AMP1_RST;
            amp2_reg <= AMP2_RST;
            cen1_reg <= CEN1_RST;
            cen2_reg <= CEN2_RST;
            wid1_reg <= WID_RST;
            wid2_reg <= WID_RST;
            coef_reg <= COEF_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_AMP1: amp1_reg <= $signed(cfg_data[17:0]);
                CFG_AMP2: amp2_reg <= $signed(cfg_data[17:0]);
                CFG_CEN1: cen1_reg <= $signed(cfg_data[20:0]);
                CFG_CEN2: cen2_reg <= $signed(cfg_data[20:0]);
                CFG_WID1: wid1_reg <= cfg_data[17:0];
                CFG_WID2: wid2_reg <= cfg_data[17:0];
                CFG_COEF: coef_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // side band line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dens_line_reg[0] <= density;
            bad_line_reg[0]  <= (scale_factor == '0);
        end
    end

    genvar s;
    generate
        for (s = 1; s < PRE_LAT; s++)
        begin : g_line
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dens_line_reg[s] <= dens_line_reg[s-1];
                    bad_line_reg[s]  <= bad_line_reg[s-1];
                end
            end
        end
    endgenerate

    // ln(scale factor)
    tgh_log #(
        .STAGES (CORDIC_STAGES)
    ) u_log (
        .clk          (clk),
        .en           (en),
        .scale_factor (scale_factor),
        .x_q32        (x_q32)
    );

    // two bumps in lock step
    tgh_bump #(
        .STAGES (CORDIC_STAGES)
    ) u_bump1 (
        .clk       (clk),
        .en        (en),
        .x_q32     (x_q32),
        .amplitude (amp1_reg),
        .centre    (cen1_reg),
        .width     (wid1_reg),
        .bump_val  (bump1),
        .clipped   (clip1)
    );

    tgh_bump #(
        .STAGES (CORDIC_STAGES)
    ) u_bump2 (
        .clk       (clk),
        .en        (en),
        .x_q32     (x_q32),
        .amplitude (amp2_reg),
        .centre    (cen2_reg),
        .width     (wid2_reg),
        .bump_val  (bump2),
        .clipped   (clip2)
    );

    // ratio, squared rate and root
    tgh_rate u_rate (
        .clk         (clk),
        .en          (en),
        .bump1       (bump1),
        .bump2       (bump2),
        .clip1       (clip1),
        .clip2       (clip2),
        .density     (dens_line_reg[PRE_LAT-1]),
        .bad_in      (bad_line_reg[PRE_LAT-1]),
        .coefficient (coef_reg),
        .res         (pipe_res)
    );

    // valid bits and result buffer
    tgh_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .en        (en),
        .pipe_res  (pipe_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign gravity_ratio  = out_res.gravity_ratio;
    assign expansion_rate = out_res.expansion_rate;
    assign bad_input      = out_res.bad_input;
    assign saturated      = out_res.saturated;

endmodule

`default_nettype wire

/* tb/twin_gaussian_log_scale_hubble_tb.sv */
// testbench for the twin gaussian gravity ratio and expansion rate pipeline
`timescale 1ns / 1ps

// Drives scale factor / density beats through a bursty valid/ready sender,
// stalls the result side on its own pattern, and checks every result beat
// field by field against an in-order queue of predicted results. The
// predictor recomputes log, bumps, ratio and rate in fixed point at the
// block's widths. Configuration changes only while the pipeline is drained.
module twin_gaussian_log_scale_hubble_tb;
    import tgh_pkg::*;

    localparam int STAGES    = 20;
    localparam int LATENCY   = 2 * STAGES + 68;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1200;

    localparam logic [63:0] LN2_C      = 64'd2977044472;
    localparam logic [63:0] LOG2E_FRAC = 64'd1901360723;
    localparam logic [63:0] MASK32     = 64'hFFFF_FFFF;
    localparam logic [63:0] DIST_MAX   = (64'd1 << 39) - 64'd1;

    typedef struct packed {
        logic [31:0] scale_factor;
        logic [31:0] density;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [31:0]        scale_factor = '0;
    logic [31:0]        density = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [18:0] gravity_ratio;
    logic [31:0]        expansion_rate;
    logic               bad_input;
    logic               saturated;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    twin_gaussian_log_scale_hubble #(.CORDIC_STAGES(STAGES)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .scale_factor   (scale_factor),
        .density        (density),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .gravity_ratio  (gravity_ratio),
        .expansion_rate (expansion_rate),
        .bad_input      (bad_input),
        .saturated      (saturated),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor: shadow copy of the seven registers
    // ---------------------------------------------------------------
    logic [31:0] shadow_cfg [7];
    logic [63:0] root_tab [33];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // amplitude * exp(-u^2/2) in Q48
    function automatic logic signed [63:0] bump_value(input logic signed [63:0] x32,
                                                    input logic [17:0] amp,
                                                    input logic [20:0] cen,
                                                    input logic [17:0] wid,
                                                    inout logic sat);
        logic signed [63:0] c;
        logic signed [63:0] d;
        logic [63:0] ud, u, uh, t, v, n, f, r;
        if (wid == 0)
            return 0;
        c = 64'(signed'(cen)) <<< 16;
        d = x32 - c;
        ud = d < 0 ? 64'(-d) : 64'(d);
        if (ud > DIST_MAX)
        begin
            ud = DIST_MAX;
            sat = 1'b1;
        end
        u = (ud << 16) / 64'(wid);
        uh = u >> 16;
        if (uh >= (64'd16 << 16))
            return 0;
        t = (uh * uh) >> 1;
        v = t + (t >> 32) * LOG2E_FRAC + (((t & MASK32) * LOG2E_FRAC) >> 32);
        n = v >> 32;
        if (n >= 33)
            return 0;
        f = v & MASK32;
        r = 64'd1 << 32;
        for (int k = 1; k <= STAGES; k++)
            if (f[32-k])
                r = (r * root_tab[k]) >> 32;
        r = r >> n;
        return 64'(signed'(amp)) * signed'(r);
    endfunction

    function automatic result_t predict_rate(input point_t pt);
        result_t res;
        logic [63:0] a, m, frac, p1, gr, hi, lo, s, add, rate;
        logic signed [63:0] x32, total, g;
        int p;
        logic sat, over;
        res = '0;
        a = 64'(pt.scale_factor);
        if (a == 0)
        begin
            res.bad_input = 1'b1;
            return res;
        end
        p = 31;
        while (a[p] == 1'b0)
            p--;
        m = a << (31 - p);
        frac = 0;
        for (int i = 1; i <= STAGES; i++)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac[32-i] = 1'b1;
            end
        end
        x32 = 64'(p - 30) * signed'(LN2_C) + signed'((frac * LN2_C) >> 32);
        sat = 1'b0;
        total = (64'sd1 <<< 48)
              + bump_value(x32, shadow_cfg[CFG_AMP1][17:0], shadow_cfg[CFG_CEN1][20:0],
                           shadow_cfg[CFG_WID1][17:0], sat)
              + bump_value(x32, shadow_cfg[CFG_AMP2][17:0], shadow_cfg[CFG_CEN2][20:0],
                           shadow_cfg[CFG_WID2][17:0], sat);
        // round half up to Q16 (arithmetic shift is a floor)
        g = (total + (64'sd1 <<< 31)) >>> 32;
        if (g < -64'sd262144)
        begin
            g = -64'sd262144;
            sat = 1'b1;
        end
        if (g > 64'sd262143)
        begin
            g = 64'sd262143;
            sat = 1'b1;
        end
        rate = 0;
        if (g > 0)
        begin
            p1 = 64'(shadow_cfg[CFG_COEF]) * 64'(pt.density);
            gr = 64'(g);
            hi = (p1 >> 32) * gr;
            lo = (p1 & MASK32) * gr;
            over = 1'b0;
            s = 0;
            if ((hi >> 48) != 0)
                over = 1'b1;
            else
            begin
                s = hi << 16;
                add = lo >> 16;
                if (s + add < s)
                    over = 1'b1;
                s = s + add;
            end
            if (over)
            begin
                rate = MASK32;
                sat = 1'b1;
            end
            else
                rate = floor_sqrt(s) & MASK32;
        end
        res.gravity_ratio = g[18:0];
        res.expansion_rate = rate[31:0];
        res.saturated = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts and gaps, fed from the pending point queue
    // ---------------------------------------------------------------
    point_t  pending_points [$];
    result_t expected_rates [$];
    int      burst_left = 0;
    int      gap_left = 0;
    bit      hold_sender = 1'b0;
    int      fail_count = 0;
    int      idle_cycles = 0;

    always @(posedge clk)
    begin
        point_t pt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_rates.push_back(predict_rate('{scale_factor, density}));
            if (in_valid && !in_ready)
                ; // hold the beat until accepted
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (!hold_sender && pending_points.size() > 0)
            begin
                pt = pending_points.pop_front();
                in_valid <= 1'b1;
                scale_factor <= pt.scale_factor;
                density <= pt.density;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // monitor: receiver stall pattern and result check
    // ---------------------------------------------------------------
    int stall_phase = 0;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            stall_phase <= stall_phase + 1;
            // long free runs alternate with stretches of random stalls
            if ((stall_phase / 300) % 2 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
            if (out_valid && out_ready)
            begin
                if (expected_rates.size() == 0)
                begin
                    $display("%t result beat with nothing expected: g=%0d rate=%0h",
                             $time, gravity_ratio, expansion_rate);
                    fail_count++;
                end
                else
                begin
                    want = expected_rates.pop_front();
                    if (gravity_ratio !== want.gravity_ratio)
                    begin
                        $display("%t gravity_ratio expected %0d actual %0d",
                                 $time, want.gravity_ratio, gravity_ratio);
                        fail_count++;
                    end
                    if (expansion_rate !== want.expansion_rate)
                    begin
                        $display("%t expansion_rate expected %0h actual %0h",
                                 $time, want.expansion_rate, expansion_rate);
                        fail_count++;
                    end
                    if (bad_input !== want.bad_input)
                    begin
                        $display("%t bad_input expected %0b actual %0b",
                                 $time, want.bad_input, bad_input);
                        fail_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $display("%t saturated expected %0b actual %0b",
                                 $time, want.saturated, saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_AMP1, CFG_AMP2, CFG_WID1, CFG_WID2: shadow_cfg[idx] = value & 32'h3FFFF;
            CFG_CEN1, CFG_CEN2:                     shadow_cfg[idx] = value & 32'h1FFFFF;
            default:                                shadow_cfg[idx] = value;
        endcase
    endtask

    task automatic write_bad_index();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait until every queued point went in and every result came back
    task automatic drain_pipeline();
        while (pending_points.size() > 0 || in_valid || expected_rates.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // random point: mostly realistic scale factors, some wild ones
    function automatic point_t random_point();
        point_t pt;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            pt.scale_factor = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
        else if (sel < 8)
            pt.scale_factor = $urandom >> $urandom_range(0, 31);
        else if (sel == 8)
            pt.scale_factor = $urandom;
        else
            pt.scale_factor = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1 << $urandom_range(0, 31);
        sel = $urandom_range(0, 3);
        if (sel == 0)
            pt.density = $urandom;
        else if (sel == 1)
            pt.density = $urandom >> $urandom_range(0, 31);
        else
            pt.density = $urandom_range(0, 32'h00FF_FFFF);
        return pt;
    endfunction

    task automatic random_config(input int mode);
        case (mode)
            0:
            begin
                // extremes
                write_reg(CFG_AMP1, 32'h1FFFF);
                write_reg(CFG_AMP2, 32'h20000);
                write_reg(CFG_CEN1, 32'h0FFFFF);
                write_reg(CFG_CEN2, 32'h100000);
                write_reg(CFG_WID1, 32'h3FFFF);
                write_reg(CFG_WID2, 32'd1);
                write_reg(CFG_COEF, 32'hFFFF_FFFF);
            end
            1:
            begin
                // a zero width, big negative amplitudes drive the ratio negative
                write_reg(CFG_AMP1, 32'h20000);
                write_reg(CFG_AMP2, 32'h20000);
                write_reg(CFG_CEN1, 32'd0);
                write_reg(CFG_CEN2, 32'd0);
                write_reg(CFG_WID1, 32'd0);
                write_reg(CFG_WID2, 32'h3FFFF);
                write_reg(CFG_COEF, 32'd0);
            end
            default:
            begin
                write_reg(CFG_AMP1, $urandom);
                write_reg(CFG_AMP2, $urandom);
                write_reg(CFG_CEN1, $urandom_range(0, 1) ? $urandom : 32'h1F0000 + $urandom_range(0, 32'h20000));
                write_reg(CFG_CEN2, $urandom_range(0, 1) ? $urandom : 32'h1F0000 + $urandom_range(0, 32'h20000));
                write_reg(CFG_WID1, $urandom_range(1, 32'h3FFFF));
                write_reg(CFG_WID2, $urandom_range(0, 32'h20000));
                write_reg(CFG_COEF, $urandom >> $urandom_range(0, 24));
            end
        endcase
        write_bad_index();
    endtask

    initial
    begin
        point_t pt;
        shadow_cfg[CFG_AMP1] = 32'd6554;
        shadow_cfg[CFG_AMP2] = 32'd3277;
        shadow_cfg[CFG_CEN1] = 32'h180000;
        shadow_cfg[CFG_CEN2] = 32'h1F8000;
        shadow_cfg[CFG_WID1] = 32'd32768;
        shadow_cfg[CFG_WID2] = 32'd32768;
        shadow_cfg[CFG_COEF] = 32'd549033;
        root_tab[0] = 64'd1 << 31;
        for (int k = 1; k <= 32; k++)
            root_tab[k] = floor_sqrt(root_tab[k-1] << 32);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset config, field extremes and special cases
        pending_points.push_back('{32'd0, 32'hFFFF_FFFF});          // zero scale factor
        pending_points.push_back('{32'd1, 32'd0});                  // smallest scale factor
        pending_points.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});  // both at maximum
        pending_points.push_back('{32'h4000_0000, 32'h0001_0000});  // a = 1.0
        pending_points.push_back('{32'h2000_0000, 32'h0010_0000});  // a = 0.5
        pending_points.push_back('{32'h0000_5A00, 32'hAAAA_5555});
        pending_points.push_back('{32'h5555_AAAA, 32'h5555_AAAA});
        pending_points.push_back('{32'hAAAA_5555, 32'd1});
        drain_pipeline();

        // extremes, then negative ratio / zero width / zero coefficient
        random_config(0);
        pending_points.push_back('{32'd1, 32'hFFFF_FFFF});          // far distance
        pending_points.push_back('{32'h4000_0000, 32'hFFFF_FFFF});  // rate overflow
        pending_points.push_back('{32'hFFFF_FFFF, 32'h8000_0000});
        pending_points.push_back('{32'h0000_0001, 32'd0});
        drain_pipeline();
        random_config(1);
        pending_points.push_back('{32'h4000_0000, 32'h0001_0000});  // ratio driven negative
        pending_points.push_back('{32'h0001_0000, 32'hFFFF_FFFF});
        pending_points.push_back('{32'hFFFF_FFFF, 32'd5});
        drain_pipeline();

        // random phases under several settings
        for (int ph = 0; ph < 8; ph++)
        begin
            random_config(ph == 0 ? 0 : 2);
            for (int i = 0; i < N_RANDOM / 8; i++)
                pending_points.push_back(random_point());
            if (ph == 3)
            begin
                // hold the sender until everything in flight has come back
                while (pending_points.size() > 60)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_rates.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tgh_pkg.sv
hw/rtl/tgh_ctrl.sv
hw/rtl/tgh_log.sv
hw/rtl/tgh_bump.sv
hw/rtl/tgh_rate.sv
hw/rtl/twin_gaussian_log_scale_hubble.sv
tb/twin_gaussian_log_scale_hubble_tb.sv
